// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the random-walk proposal checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante in one cycle implies cons in the next, ignored while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// a cycle of reset implies cons in the following cycle
`define ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("assertion failed after reset");

`endif

// ===== src/rrw_pkg.sv =====
// ----------------------------------------------------------------------------
// rrw_pkg
// Types, constants and helpers shared by the reflected random-walk proposal.
// ----------------------------------------------------------------------------
`default_nettype none

package rrw_pkg;

    // field widths fixed by the item format
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CMD_W           = 2;
    localparam int NOISE_W         = 16;
    localparam int STEP_W          = 31;
    localparam int CNT_W           = 32;
    localparam int PROD_W          = NOISE_W + STEP_W;
    localparam int FRAC_SHIFT      = 12;            // Q3.12 * Q16.16 -> Q16.16
    localparam int INC_W           = PROD_W - FRAC_SHIFT;

    // register map
    localparam int             REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_LOWER = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_UPPER = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_STEP  = 2'd2;

    // register reset values
    localparam int                UPPER_RST = 65536;    // 1.0
    localparam logic [STEP_W-1:0] STEP_RST  = 31'd19661; // about 0.3

    typedef enum logic [CMD_W-1:0] {
        CMD_PROPOSE = 2'd0,
        CMD_ACCEPT  = 2'd1,
        CMD_REJECT  = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CHK,
        ST_DIV,
        ST_FOLD,
        ST_RLO,
        ST_RHI,
        ST_OUT
    } t_state;

    // saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== src/reflected_random_walk_proposal.sv =====
// ----------------------------------------------------------------------------
// reflected_random_walk_proposal
// Proposal step of a Metropolis sampler with reflecting bounds, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries a command, the current
//   value and a Q3.12 noise sample; output channel (o_out_valid /
//   i_out_ready) returns one result per command. Bounds and step size are
//   written over the APB port; the user must write them only while the
//   block is idle, which the block does not enforce; pready is always high.
//   One item is worked at a time. Accept, reject and clear go straight from
//   idle to the output load. A propose runs the bit-serial noise multiply,
//   then sum, range check, two reflect steps and the output load; an empty
//   range skips the reflect steps and returns the lower bound. A far
//   overshoot adds the bit-per-cycle remainder division by twice the bound
//   width and a fold step. The next item is taken the cycle after the
//   result is loaded.
//   The result sits in an output register, so the next item is taken while
//   it waits; if the receiver stalls, the following result waits in the
//   last step until the register frees up.
//   Synchronous reset clears flags, counters, saved value and output valid,
//   and loads the bound and step reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module reflected_random_walk_proposal #(
    parameter  int VALUE_WIDTH = rrw_pkg::VALUE_WIDTH_DEF,
    localparam int DATA_W      = (VALUE_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_W      = rrw_pkg::REG_IDX_W + ((VALUE_WIDTH > 32) ? 3 : 2)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [ADDR_W-1:0]            paddr,
    input  logic        [DATA_W-1:0]            pwdata,
    output logic        [DATA_W-1:0]            prdata,
    output logic                                pready,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic        [rrw_pkg::CMD_W-1:0]    i_cmd,
    input  logic signed [VALUE_WIDTH-1:0]       i_current_value,
    input  logic signed [rrw_pkg::NOISE_W-1:0]  i_noise_sample,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [VALUE_WIDTH-1:0]       o_new_value,
    output logic                                o_low_shock,
    output logic                                o_high_shock,
    output logic        [rrw_pkg::CNT_W-1:0]    o_low_shock_count,
    output logic        [rrw_pkg::CNT_W-1:0]    o_high_shock_count
);
    import rrw_pkg::*;

    localparam int W   = VALUE_WIDTH;
    localparam int XW  = W + 3;                          // working width
    localparam int DW  = W + 1;                          // divider width
    localparam int SW  = ((W > INC_W) ? W : INC_W) + 1;  // raw sum width
    localparam int ASH = ADDR_W - REG_IDX_W;

    // configuration registers
    logic signed [W-1:0]      r_lo;
    logic signed [W-1:0]      r_hi;
    logic        [STEP_W-1:0] r_step;

    // control and architectural state
    t_state                   r_state;
    t_state                   n_state;
    t_cmd                     r_cmd;
    logic signed [W-1:0]      r_cur;
    logic signed [W-1:0]      r_saved;
    logic                     r_lf;
    logic                     r_hf;
    logic        [CNT_W-1:0]  r_lc;
    logic        [CNT_W-1:0]  r_hc;
    logic                     r_ovalid;
    logic signed [W-1:0]      r_onew;

    // propose datapath
    logic signed [XW-1:0]     r_v;
    logic                     r_below;
    logic                     r_pl;
    logic                     r_ph;

    // next values at output load
    logic                     n_lf;
    logic                     n_hf;
    logic        [CNT_W-1:0]  n_lc;
    logic        [CNT_W-1:0]  n_hc;
    logic signed [W-1:0]      n_new;

    logic [REG_IDX_W-1:0]     w_idx;
    logic                     w_cfg_wr;
    logic                     w_in_ready;
    logic                     w_in_xfer;
    logic                     w_mul_start;
    logic                     w_mul_done;
    logic                     w_div_start;
    logic                     w_div_done;
    logic                     w_out_load;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [INC_W-1:0]  w_inc;
    logic signed [SW-1:0]     w_sum;
    logic                     w_ovf_hi;
    logic                     w_ovf_lo;
    logic signed [W-1:0]      w_sat;
    logic signed [XW-1:0]     w_lo_x;
    logic signed [XW-1:0]     w_hi_x;
    logic signed [XW-1:0]     w_d;
    logic                     w_bad;
    logic                     w_fold_dn;
    logic                     w_fold_up;
    logic                     w_chk_fold;
    logic signed [XW-1:0]     w_dvd_x;
    logic        [DW-1:0]     w_dvs;
    logic        [DW-1:0]     w_rem;
    logic signed [XW-1:0]     w_rem_x;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_idx    = paddr[ADDR_W-1:ASH];
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo   <= '0;
            r_hi   <= W'(UPPER_RST);
            r_step <= STEP_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_LOWER: r_lo   <= pwdata[W-1:0];
                REG_UPPER: r_hi   <= pwdata[W-1:0];
                REG_STEP:  r_step <= pwdata[STEP_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_LOWER: prdata = DATA_W'(r_lo);
            REG_UPPER: prdata = DATA_W'(r_hi);
            REG_STEP:  prdata = DATA_W'(r_step);
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Serial units
    // ------------------------------------------------------------------
    rrw_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_noise (i_noise_sample),
        .i_step  (r_step),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    rrw_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd_x[DW-1:0]),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // ------------------------------------------------------------------
    // Propose arithmetic
    // ------------------------------------------------------------------
    // floor(prod / 4096), then saturating add to the current value
    assign w_inc    = w_prod[PROD_W-1:FRAC_SHIFT];
    assign w_sum    = SW'(r_cur) + SW'(w_inc);
    assign w_ovf_hi = !w_sum[SW-1] && (|w_sum[SW-2:W-1]);
    assign w_ovf_lo = w_sum[SW-1] && !(&w_sum[SW-2:W-1]);

    always_comb begin
        if (w_ovf_hi) begin
            w_sat = {1'b0, {(W-1){1'b1}}};
        end else if (w_ovf_lo) begin
            w_sat = {1'b1, {(W-1){1'b0}}};
        end else begin
            w_sat = w_sum[W-1:0];
        end
    end

    // bound checks: empty range, far overshoot below or above
    assign w_lo_x     = XW'(r_lo);
    assign w_hi_x     = XW'(r_hi);
    assign w_d        = w_hi_x - w_lo_x;
    assign w_bad      = (r_hi <= r_lo);
    assign w_fold_dn  = (r_v <= w_lo_x - w_d);
    assign w_fold_up  = (r_v >= w_hi_x + w_d);
    assign w_chk_fold = !w_bad && (w_fold_dn || w_fold_up);

    // fold keeps only the remainder modulo twice the width
    assign w_dvd_x = w_fold_dn ? (w_hi_x - r_v) : (r_v - w_lo_x);
    assign w_dvs   = {w_d[W-1:0], 1'b0};
    assign w_rem_x = XW'(w_rem);

    // ------------------------------------------------------------------
    // Control FSM
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (t_cmd'(i_cmd) == CMD_PROPOSE) ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: n_state = ST_CHK;
            ST_CHK: begin
                if (w_bad) begin
                    n_state = ST_OUT;
                end else if (w_chk_fold) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_RLO;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: n_state = ST_RLO;
            ST_RLO:  n_state = ST_RHI;
            ST_RHI:  n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: w_in_ready  = 1'b1;
            ST_CHK:  w_div_start = w_chk_fold;
            ST_OUT:  w_out_load  = !r_ovalid || i_out_ready;
            default: ;
        endcase
    end

    assign w_in_xfer   = w_in_ready && i_in_valid;
    assign w_mul_start = w_in_xfer && (t_cmd'(i_cmd) == CMD_PROPOSE);

    // ------------------------------------------------------------------
    // Working value and pending flags
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    r_cmd <= t_cmd'(i_cmd);
                    r_cur <= i_current_value;
                    r_pl  <= r_lf;
                    r_ph  <= r_hf;
                end
            end
            ST_SUM: r_v <= XW'(w_sat);
            ST_CHK: begin
                r_below <= w_fold_dn;
                if (w_bad) begin
                    r_v <= w_lo_x;
                end
            end
            ST_FOLD: begin
                r_v  <= r_below ? (w_hi_x - w_rem_x) : (w_lo_x + w_rem_x);
                r_pl <= 1'b1;
                r_ph <= 1'b1;
            end
            ST_RLO: begin
                if (r_v < w_lo_x) begin
                    r_v  <= (w_lo_x <<< 1) - r_v;
                    r_pl <= 1'b1;
                end
            end
            ST_RHI: begin
                if (r_v > w_hi_x) begin
                    r_v  <= (w_hi_x <<< 1) - r_v;
                    r_ph <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Result of the command
    // ------------------------------------------------------------------
    always_comb begin
        n_lf  = r_lf;
        n_hf  = r_hf;
        n_lc  = r_lc;
        n_hc  = r_hc;
        n_new = r_cur;
        unique case (r_cmd)
            CMD_PROPOSE: begin
                n_lf  = r_pl;
                n_hf  = r_ph;
                n_lc  = r_pl ? sat_inc(r_lc) : r_lc;
                n_hc  = r_ph ? sat_inc(r_hc) : r_hc;
                n_new = r_v[W-1:0];
            end
            CMD_ACCEPT: begin
                n_lf = 1'b0;
                n_hf = 1'b0;
            end
            CMD_REJECT: begin
                n_lf  = 1'b0;
                n_hf  = 1'b0;
                n_new = r_saved;
            end
            CMD_CLEAR: begin
                n_lc = '0;
                n_hc = '0;
            end
            default: ;
        endcase
    end

    // sampler state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saved  <= '0;
            r_lf     <= 1'b0;
            r_hf     <= 1'b0;
            r_lc     <= '0;
            r_hc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_mul_start) begin
                r_saved <= i_current_value;
            end
            if (w_out_load) begin
                r_lf     <= n_lf;
                r_hf     <= n_hf;
                r_lc     <= n_lc;
                r_hc     <= n_hc;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output value register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_onew <= n_new;
        end
    end

    assign o_in_ready         = w_in_ready;
    assign o_out_valid        = r_ovalid;
    assign o_new_value        = r_onew;
    assign o_low_shock        = r_lf;
    assign o_high_shock       = r_hf;
    assign o_low_shock_count  = r_lc;
    assign o_high_shock_count = r_hc;

endmodule

`default_nettype wire

// ===== src/rrw_mul.sv =====
// ----------------------------------------------------------------------------
// rrw_mul
// Bit-serial signed noise times unsigned step, one noise bit per cycle, MSB
// first (Horner form; the sign bit weighs negative).
// ----------------------------------------------------------------------------
`default_nettype none

module rrw_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [rrw_pkg::NOISE_W-1:0]  i_noise,
    input  logic        [rrw_pkg::STEP_W-1:0]   i_step,
    output logic                                 o_done,
    output logic signed [rrw_pkg::PROD_W-1:0]   o_prod
);
    import rrw_pkg::*;

    localparam int CW = $clog2(NOISE_W + 1);

    logic        [NOISE_W-1:0] r_nse;
    logic signed [PROD_W-1:0]  r_acc;
    logic        [CW-1:0]      r_cnt;
    logic                      r_done;
    logic signed [PROD_W-1:0]  w_add;

    // partial product for the current noise bit
    assign w_add = r_nse[NOISE_W-1] ? $signed({{(PROD_W-STEP_W){1'b0}}, i_step}) : '0;

    // bit counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(NOISE_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-add accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nse <= i_noise;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_nse <= r_nse << 1;
            if (r_cnt == CW'(NOISE_W)) begin
                r_acc <= -w_add;
            end else begin
                r_acc <= (r_acc <<< 1) + w_add;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ===== src/rrw_div.sv =====
// ----------------------------------------------------------------------------
// rrw_div
// Restoring divider, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module rrw_div #(
    parameter int DW = rrw_pkg::VALUE_WIDTH_DEF + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_dvd;
    logic [DW-1:0] r_dvs;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // trial subtract of the shifted partial remainder
    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== src/rrw_checker.sv =====
// ----------------------------------------------------------------------------
// rrw_checker
// Port-level checks of the random-walk proposal, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rrw_checker #(
    parameter int VALUE_WIDTH = rrw_pkg::VALUE_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [VALUE_WIDTH-1:0] o_new_value
);

    // one item at a time: an input transfer makes the block busy
    `ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // and keeps its value
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_new_value))

    // reset leaves the block empty and ready
    `ASSERT_AFTER_RESET(a_reset_idle, i_clk, i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind reflected_random_walk_proposal rrw_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_rrw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_new_value (o_new_value)
);

`default_nettype wire
